@@ hw/rtl/stack_machine_executor_defines.svh @@
// Assertion macros for the stack machine executor RTL.
// Both macros sample on the rising edge of clk in the module that uses them.
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define SMX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define SMX_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMX_ASSERT(lbl, prop, msg)
`define SMX_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/smx_pkg.sv @@
`default_nettype none

package smx_pkg;

	localparam int STACK_DEPTH_DEF = 256;
	localparam int LABEL_COUNT     = 9;
	localparam int DATA_W          = 32;

	typedef enum logic [3:0] {
		OP_PUSH_REG = 4'd0,
		OP_PUSH_IMM = 4'd1,
		OP_POP_REG  = 4'd2,
		OP_ADD      = 4'd3,
		OP_MUL      = 4'd4,
		OP_JMP      = 4'd5,
		OP_JBE      = 4'd6,
		OP_LABEL    = 4'd7,
		OP_OUT      = 4'd8,
		OP_END      = 4'd9
	} op_kind_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_OVER   = 3'd1,
		ST_UNDER  = 3'd2,
		ST_BADREG = 3'd3,
		ST_BADOP  = 3'd4
	} status_t;

	// Movement of the whole stack for one command.
	typedef enum logic [2:0] {
		STK_HOLD,
		STK_PUSH,
		STK_POP1,
		STK_POP2,
		STK_REPL
	} stk_op_t;

	// What a single cell loads on the next edge.
	typedef enum logic [2:0] {
		SEL_HOLD,
		SEL_NEW,
		SEL_UP,
		SEL_DN1,
		SEL_DN2
	} cell_sel_t;

	typedef struct packed {
		stk_op_t           op;
		logic [DATA_W-1:0] wdata;
	} stk_cmd_t;

	typedef struct packed {
		logic [3:0]         kind;
		logic signed [31:0] operand;
	} instr_t;

	typedef struct packed {
		logic               out_valid;
		logic signed [31:0] out_value;
		logic               branch_taken;
		logic [3:0]         branch_label;
		logic               halted;
		logic [2:0]         status;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/smx_chan_if.sv @@
`default_nettype none

interface smx_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ hw/rtl/smx_cell.sv @@
`default_nettype none

module smx_cell (
	input  wire                        clk,
	input  smx_pkg::cell_sel_t         sel,
	input  wire [smx_pkg::DATA_W-1:0]  new_val,
	input  wire [smx_pkg::DATA_W-1:0]  up_val,
	input  wire [smx_pkg::DATA_W-1:0]  dn1_val,
	input  wire [smx_pkg::DATA_W-1:0]  dn2_val,
	output logic [smx_pkg::DATA_W-1:0] data_q
);
	import smx_pkg::*;

	always_ff @(posedge clk) begin
		case (sel)
			SEL_NEW: data_q <= new_val;
			SEL_UP:  data_q <= up_val;
			SEL_DN1: data_q <= dn1_val;
			SEL_DN2: data_q <= dn2_val;
			default: data_q <= data_q;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/smx_stack.sv @@
`default_nettype none

module smx_stack #(
	parameter int DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
	input  wire                        clk,
	input  smx_pkg::stk_cmd_t          cmd,
	output logic [smx_pkg::DATA_W-1:0] top0,
	output logic [smx_pkg::DATA_W-1:0] top1
);
	import smx_pkg::*;

	// Cell 0 is the top of stack. Two extra slots past the bottom feed the
	// dn1 and dn2 paths of the last cells with zeros.
	logic [DATA_W-1:0] val [DEPTH+2];

	assign val[DEPTH]   = '0;
	assign val[DEPTH+1] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam int UP = (i == 0) ? 0 : i - 1;
		cell_sel_t sel;

		always_comb begin
			case (cmd.op)
				STK_PUSH: sel = (i == 0) ? SEL_NEW : SEL_UP;
				STK_POP1: sel = SEL_DN1;
				STK_POP2: sel = SEL_DN2;
				STK_REPL: sel = (i == 0) ? SEL_NEW : SEL_DN1;
				default:  sel = SEL_HOLD;
			endcase
		end

		smx_cell u_cell (
			.clk     (clk),
			.sel     (sel),
			.new_val (cmd.wdata),
			.up_val  (val[UP]),
			.dn1_val (val[i+1]),
			.dn2_val (val[i+2]),
			.data_q  (val[i])
		);
	end

	assign top0 = val[0];
	assign top1 = val[1];

endmodule

`default_nettype wire

@@ hw/rtl/stack_machine_executor.sv @@
// Stack machine executor.
// The instr channel takes one instruction per transaction (kind, operand);
// the result channel returns exactly one result transaction per instruction,
// in order: emitted value, branch request with label, halt flag and status.
// Jumps only report a label; the host sequences the program.
// The value stack is a row of cells, the top entry in the first cell. Every
// instruction moves the whole row by at most two places at once, so
// each instruction executes in the cycle it is accepted.
// The result is registered and becomes valid in the cycle after the instruction is accepted.
// Throughput: one instruction per cycle while the result receiver does not stall.
// The result sits in an output register; while the receiver stalls it is
// held, and instr ready stays high only as long as that register is empty or
// being emptied in the same cycle.
// Reset empties the stack, clears the four general registers and the halt
// flag and drops any pending result. After an end instruction all further
// instructions are consumed and answered with halted set and nothing else.
`default_nettype none
`include "stack_machine_executor_defines.svh"

module stack_machine_executor #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	smx_chan_if.sink    instr,
	smx_chan_if.source  result
);
	import smx_pkg::*;

	localparam int SP_W = $clog2(STACK_DEPTH + 1);

	logic [SP_W-1:0]   sp_q;
	logic [SP_W-1:0]   sp_d;
	logic [DATA_W-1:0] gpr_q [4];
	logic              gpr_we;
	logic              halt_q;
	logic              halt_d;
	result_t           res_q;
	result_t           res_d;
	logic              res_valid_q;
	stk_cmd_t          cmd;
	logic [DATA_W-1:0] top0;
	logic [DATA_W-1:0] top1;
	logic              accept;
	logic              full;
	logic              lt1;
	logic              lt2;
	logic              bad_reg;
	logic              bad_lbl;
	logic [1:0]        ridx;

	assign instr.ready  = !res_valid_q || result.ready;
	assign accept       = instr.valid && instr.ready;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	assign full    = sp_q == SP_W'(STACK_DEPTH);
	assign lt1     = sp_q == '0;
	assign lt2     = sp_q < SP_W'(2);
	assign ridx    = instr.data.operand[1:0];
	assign bad_reg = |instr.data.operand[31:2];
	assign bad_lbl = $unsigned(instr.data.operand) >= 32'(LABEL_COUNT);

	smx_stack #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.cmd  (cmd),
		.top0 (top0),
		.top1 (top1)
	);

	always_comb begin
		res_d     = '0;
		cmd.op    = STK_HOLD;
		cmd.wdata = instr.data.operand;
		sp_d      = sp_q;
		gpr_we    = 1'b0;
		halt_d    = halt_q;
		if (accept && !halt_q) begin
			case (instr.data.kind)
				OP_PUSH_REG: begin
					if (bad_reg) begin
						res_d.status = ST_BADREG;
					end else if (full) begin
						res_d.status = ST_OVER;
					end else begin
						cmd.op    = STK_PUSH;
						cmd.wdata = gpr_q[ridx];
						sp_d      = sp_q + SP_W'(1);
					end
				end
				OP_PUSH_IMM: begin
					if (full) begin
						res_d.status = ST_OVER;
					end else begin
						cmd.op = STK_PUSH;
						sp_d   = sp_q + SP_W'(1);
					end
				end
				OP_POP_REG: begin
					if (bad_reg) begin
						res_d.status = ST_BADREG;
					end else if (lt1) begin
						res_d.status = ST_UNDER;
					end else begin
						cmd.op = STK_POP1;
						gpr_we = 1'b1;
						sp_d   = sp_q - SP_W'(1);
					end
				end
				OP_ADD, OP_MUL: begin
					if (lt2) begin
						res_d.status = ST_UNDER;
					end else begin
						cmd.op    = STK_REPL;
						cmd.wdata = (instr.data.kind == OP_ADD) ? top0 + top1 : top0 * top1;
						sp_d      = sp_q - SP_W'(1);
					end
				end
				OP_JMP: begin
					if (bad_lbl) begin
						res_d.status = ST_BADREG;
					end else begin
						res_d.branch_taken = 1'b1;
						res_d.branch_label = instr.data.operand[3:0];
					end
				end
				OP_JBE: begin
					if (bad_lbl) begin
						res_d.status = ST_BADREG;
					end else if (lt2) begin
						res_d.status = ST_UNDER;
					end else begin
						cmd.op = STK_POP2;
						sp_d   = sp_q - SP_W'(2);
						// The deeper entry must be strictly greater than the top one.
						if ($signed(top1) > $signed(top0)) begin
							res_d.branch_taken = 1'b1;
							res_d.branch_label = instr.data.operand[3:0];
						end
					end
				end
				OP_LABEL: begin
					res_d.status = ST_OK;
				end
				OP_OUT: begin
					if (lt1) begin
						res_d.status = ST_UNDER;
					end else begin
						cmd.op          = STK_POP1;
						sp_d            = sp_q - SP_W'(1);
						res_d.out_valid = 1'b1;
						res_d.out_value = top0;
					end
				end
				OP_END: begin
					halt_d = 1'b1;
				end
				default: begin
					res_d.status = ST_BADOP;
				end
			endcase
		end
		res_d.halted = halt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			halt_q      <= 1'b0;
			res_valid_q <= 1'b0;
			for (int r = 0; r < 4; r++) begin
				gpr_q[r] <= '0;
			end
		end else begin
			sp_q   <= sp_d;
			halt_q <= halt_d;
			if (gpr_we) begin
				gpr_q[ridx] <= top0;
			end
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	`SMX_ASSERT(a_sp_in_range, sp_q <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
	`SMX_ASSERT(a_halt_sticky, halt_q |=> halt_q, "halt flag cleared without reset")
	`SMX_ASSERT(a_halt_freezes_sp, halt_q |=> $stable(sp_q), "stack moved while halted")
	`SMX_ASSERT_ALWAYS(a_branch_clean, (res_valid_q && res_q.branch_taken) |-> (res_q.status == ST_OK && !res_q.out_valid), "branch result carries error or value")

endmodule

`default_nettype wire

@@ tb/stack_machine_executor_checker.sv @@
module stack_machine_executor_checker #(
	parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	smx_chan_if         instr,
	smx_chan_if         result,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned checked
);

	import smx_pkg::*;

	logic [31:0] value_stack [STACK_DEPTH];
	int unsigned stack_level;
	logic [31:0] gp_regs [4];
	bit          halt_seen;
	result_t     expected_results [$];

	assign pending = expected_results.size();

	// Executes one instruction on the shadow machine and returns its result.
	function automatic result_t execute_instr(input instr_t ins);
		result_t     r;
		logic [31:0] opnd;
		logic [31:0] top_v;
		logic [31:0] next_v;
		r = '0;
		opnd = ins.operand;
		if (!halt_seen) begin
			case (ins.kind)
				OP_PUSH_REG: begin
					if (opnd > 32'd3) r.status = ST_BADREG;
					else if (stack_level >= STACK_DEPTH) r.status = ST_OVER;
					else begin
						value_stack[stack_level] = gp_regs[opnd[1:0]];
						stack_level++;
					end
				end
				OP_PUSH_IMM: begin
					if (stack_level >= STACK_DEPTH) r.status = ST_OVER;
					else begin
						value_stack[stack_level] = opnd;
						stack_level++;
					end
				end
				OP_POP_REG: begin
					if (opnd > 32'd3) r.status = ST_BADREG;
					else if (stack_level == 0) r.status = ST_UNDER;
					else begin
						stack_level--;
						gp_regs[opnd[1:0]] = value_stack[stack_level];
					end
				end
				OP_ADD, OP_MUL: begin
					if (stack_level < 2) r.status = ST_UNDER;
					else begin
						top_v = value_stack[stack_level - 1];
						next_v = value_stack[stack_level - 2];
						value_stack[stack_level - 2] = (ins.kind == OP_ADD) ?
							top_v + next_v : top_v * next_v;
						stack_level--;
					end
				end
				OP_JMP: begin
					if (opnd >= LABEL_COUNT) r.status = ST_BADREG;
					else begin
						r.branch_taken = 1'b1;
						r.branch_label = opnd[3:0];
					end
				end
				OP_JBE: begin
					if (opnd >= LABEL_COUNT) r.status = ST_BADREG;
					else if (stack_level < 2) r.status = ST_UNDER;
					else begin
						top_v = value_stack[stack_level - 1];
						next_v = value_stack[stack_level - 2];
						stack_level -= 2;
						// Both entries go away whether or not the branch is taken.
						if ($signed(next_v) > $signed(top_v)) begin
							r.branch_taken = 1'b1;
							r.branch_label = opnd[3:0];
						end
					end
				end
				OP_LABEL: ;
				OP_OUT: begin
					if (stack_level == 0) r.status = ST_UNDER;
					else begin
						stack_level--;
						r.out_valid = 1'b1;
						r.out_value = value_stack[stack_level];
					end
				end
				OP_END: halt_seen = 1'b1;
				default: r.status = ST_BADOP;
			endcase
		end
		r.halted = halt_seen;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (want_v !== got_v) begin
			if (mismatches < 10)
				$display("%0t: result %0d: %s expected %0h, got %0h",
					$time, checked, field, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			expected_results.delete();
			stack_level = 0;
			for (int i = 0; i < 4; i++) gp_regs[i] = '0;
			halt_seen = 1'b0;
			mismatches = 0;
			checked = 0;
		end else begin
			if (instr.valid && instr.ready)
				expected_results.push_back(execute_instr(instr.data));
			if (result.valid && result.ready) begin
				got = result.data;
				if (expected_results.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result transaction with nothing expected", $time);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("out_valid", want.out_valid, got.out_valid);
					check_field("out_value", want.out_value, got.out_value);
					check_field("branch_taken", want.branch_taken, got.branch_taken);
					check_field("branch_label", want.branch_label, got.branch_label);
					check_field("halted", want.halted, got.halted);
					check_field("status", want.status, got.status);
				end
				checked++;
			end
		end
	end

endmodule

@@ tb/stack_machine_executor_tb.sv @@
module stack_machine_executor_tb;

	import smx_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 900;
	localparam int unsigned HOLD_CYCLES  = 150;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bit steady = 1'b0;
	bit hold_off = 1'b0;
	bit hold_done = 1'b0;

	int unsigned stack_level_est = 0;
	int unsigned sent_count = 0;
	int unsigned random_count = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatches;
	int unsigned pending;
	int unsigned checked;

	smx_chan_if #(.payload_t(instr_t))  instr_ch ();
	smx_chan_if #(.payload_t(result_t)) result_ch ();

	stack_machine_executor dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	stack_machine_executor_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.instr      (instr_ch),
		.result     (result_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, pending);
			$display("stack_machine_executor_tb: done, errors");
			$finish;
		end
	end

	// Result receiver: random stalls, a steady stretch, and one long hold-off.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off && !hold_done) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				result_ch.ready <= steady || ($urandom_range(99) >= 37);
			end
		end
	end

	function automatic logic [31:0] random_word();
		if ($urandom_range(3) == 0) return 32'($urandom_range(20)) - 32'd10;
		return $urandom;
	endfunction

	// Sends one instruction and waits for its transaction; valid stays high afterwards.
	task automatic issue(input logic [3:0] kind, input logic [31:0] operand);
		while (!steady && $urandom_range(99) < 37) begin
			instr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.data <= '{kind: kind, operand: operand};
		@(posedge clk);
		while (!instr_ch.ready) @(posedge clk);
		case (kind)
			OP_PUSH_REG: if (operand <= 32'd3 && stack_level_est < STACK_DEPTH_DEF)
				stack_level_est++;
			OP_PUSH_IMM: if (stack_level_est < STACK_DEPTH_DEF) stack_level_est++;
			OP_POP_REG: if (operand <= 32'd3 && stack_level_est > 0) stack_level_est--;
			OP_ADD, OP_MUL: if (stack_level_est >= 2) stack_level_est--;
			OP_JBE: if (operand < LABEL_COUNT && stack_level_est >= 2) stack_level_est -= 2;
			OP_OUT: if (stack_level_est > 0) stack_level_est--;
			default: ;
		endcase
		sent_count++;
	endtask

	task automatic issue_well_formed();
		int unsigned pick;
		pick = $urandom_range(99);
		// A deep stack leans toward instructions that consume entries.
		if (stack_level_est >= 200) pick = $urandom_range(99, 34);
		if (pick < 22 || stack_level_est == 0) issue(OP_PUSH_IMM, random_word());
		else if (pick < 32) issue(OP_PUSH_REG, $urandom_range(3));
		else if (pick < 44) issue(OP_POP_REG, $urandom_range(3));
		else if (stack_level_est < 2) issue(OP_PUSH_REG, $urandom_range(3));
		else if (pick < 56) issue(OP_ADD, $urandom);
		else if (pick < 66) issue(OP_MUL, $urandom);
		else if (pick < 76) issue(OP_JBE, $urandom_range(LABEL_COUNT - 1));
		else if (pick < 82) issue(OP_JMP, $urandom_range(LABEL_COUNT - 1));
		else if (pick < 86) issue(OP_LABEL, $urandom);
		else issue(OP_OUT, $urandom);
	endtask

	// Pushes a few terms, folds them with add or multiply, then consumes the result.
	task automatic issue_expression();
		int unsigned terms;
		terms = $urandom_range(5, 2);
		repeat (terms) begin
			if ($urandom_range(3) == 0) issue(OP_PUSH_REG, $urandom_range(3));
			else issue(OP_PUSH_IMM, random_word());
		end
		repeat (terms - 1) issue($urandom_range(1) ? OP_ADD : OP_MUL, $urandom);
		if ($urandom_range(1)) issue(OP_OUT, 0);
		else issue(OP_POP_REG, $urandom_range(3));
	endtask

	task automatic issue_noise();
		logic [3:0] kind;
		do kind = 4'($urandom_range(15)); while (kind == OP_END);
		issue(kind, $urandom_range(1) ? $urandom : $urandom_range(12));
	endtask

	initial begin : stimulus
		int unsigned target;
		bit filled;
		filled = 1'b0;
		instr_ch.valid <= 1'b0;
		instr_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack: consumers underflow, and index errors take priority.
		issue(OP_OUT, 0);
		issue(OP_POP_REG, 0);
		issue(OP_ADD, 0);
		issue(OP_JBE, 0);
		issue(OP_PUSH_REG, 4);
		issue(OP_POP_REG, 32'hFFFF_FFFF);
		issue(OP_JMP, LABEL_COUNT);
		issue(OP_JBE, 32'h8000_0000);
		issue(4'd10, 0);
		issue(4'd15, 32'hFFFF_FFFF);
		// Signed compare at the extremes takes the branch to the last label.
		issue(OP_PUSH_IMM, 32'h7FFF_FFFF);
		issue(OP_PUSH_IMM, 32'h8000_0000);
		issue(OP_JBE, LABEL_COUNT - 1);
		issue(OP_PUSH_IMM, 32'hFFFF_FFFF);
		issue(OP_PUSH_IMM, 1);
		issue(OP_ADD, 0);
		issue(OP_OUT, 0);
		issue(OP_PUSH_IMM, 32'h0001_0000);
		issue(OP_PUSH_IMM, 32'h0001_0001);
		issue(OP_MUL, 0);
		issue(OP_POP_REG, 3);
		issue(OP_PUSH_REG, 3);
		issue(OP_OUT, 0);
		issue(OP_PUSH_IMM, 5);
		issue(OP_PUSH_IMM, 5);
		issue(OP_JBE, 1);
		issue(OP_JMP, 0);
		issue(OP_LABEL, 32'h1234_5678);

		target = sent_count + RANDOM_ITEMS;
		while (sent_count < target) begin
			steady = (sent_count + 750 >= target) && (sent_count + 600 < target);
			if (!filled && sent_count + 500 >= target) begin
				// Fill the stack with the receiver held off so the input stalls.
				hold_off = 1'b1;
				steady = 1'b1;
				while (stack_level_est < STACK_DEPTH_DEF) issue(OP_PUSH_IMM, random_word());
				issue(OP_PUSH_REG, 7);
				issue(OP_PUSH_IMM, $urandom);
				issue(OP_PUSH_REG, 2);
				hold_off = 1'b0;
				steady = 1'b0;
				filled = 1'b1;
			end else begin
				case ($urandom_range(99)) inside
					[0:59]: issue_well_formed();
					[60:81]: issue_expression();
					default: issue_noise();
				endcase
			end
		end
		random_count = sent_count - (target - RANDOM_ITEMS);

		// After end every instruction is answered with only the halted flag.
		issue(OP_END, $urandom);
		repeat (6) issue(4'($urandom_range(15)), $urandom_range(1) ? $urandom : 0);
		instr_ch.valid <= 1'b0;

		// The edge below lets the checker record the last accepted instruction.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d instructions (%0d random) and checked %0d results.",
			sent_count, random_count, checked);
		$display("Covered every opcode and error status, a full stack with overflow, "
			, "a long result stall, and instructions after halt.");
		if (mismatches == 0)
			$display("stack_machine_executor_tb: done, clean");
		else
			$display("stack_machine_executor_tb: done, errors");
		$finish;
	end

endmodule
